FILE: rtl/mdc_pkg.sv
// Shared types, codes and wall-bit tables of the maze carver.
package mdc_pkg;

    // Grid size default and fixed field widths
    localparam int GRID_SIDE_DEF = 8;
    localparam int CELL_W        = 5;
    localparam int CMD_W         = 3;
    localparam int STAT_W        = 3;
    localparam int COORD_W       = 3;
    localparam int DATA_W        = 16;

    // Commands
    localparam logic [CMD_W-1:0] CMD_CLEAR_GRID = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR_BITS = 3'd1;
    localparam logic [CMD_W-1:0] CMD_START      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STEP       = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ       = 3'd4;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_MOVED    = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_MOVE  = 3'd1;
    localparam logic [STAT_W-1:0] ST_FINISHED = 3'd2;
    localparam logic [STAT_W-1:0] ST_READ     = 3'd3;
    localparam logic [STAT_W-1:0] ST_ACK      = 3'd4;

    // Cell bits
    localparam logic [CELL_W-1:0] BIT_DOWN      = 5'd1;
    localparam logic [CELL_W-1:0] BIT_LEFT      = 5'd2;
    localparam logic [CELL_W-1:0] BIT_UP        = 5'd4;
    localparam logic [CELL_W-1:0] BIT_RIGHT     = 5'd8;
    localparam logic [CELL_W-1:0] BIT_UNVISITED = 5'd16;
    localparam logic [CELL_W-1:0] BITS_ALL      = 5'd31;
    localparam int                UNV_POS       = 4;

    // Walk directions
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    // Neighbor selector of the address unit: the cell itself, then one per direction
    typedef enum logic [2:0] {
        NB_HERE  = 3'd0,
        NB_UP    = 3'd1,
        NB_LEFT  = 3'd2,
        NB_RIGHT = 3'd3,
        NB_DOWN  = 3'd4
    } t_nsel;

    // Wall of the current cell that a move in direction d opens
    function automatic logic [CELL_W-1:0] own_wall(input logic [1:0] d);
        logic [CELL_W-1:0] w;
        unique case (d)
            DIR_UP:    w = BIT_UP;
            DIR_LEFT:  w = BIT_LEFT;
            DIR_RIGHT: w = BIT_RIGHT;
            default:   w = BIT_DOWN;
        endcase
        return w;
    endfunction

    // Wall of the entered cell that faces back
    function automatic logic [CELL_W-1:0] far_wall(input logic [1:0] d);
        logic [CELL_W-1:0] w;
        unique case (d)
            DIR_UP:    w = BIT_DOWN;
            DIR_LEFT:  w = BIT_RIGHT;
            DIR_RIGHT: w = BIT_LEFT;
            default:   w = BIT_UP;
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/mdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mdc_ram #(
    parameter int WIDTH = mdc_pkg::CELL_W,
    parameter int DEPTH = mdc_pkg::GRID_SIDE_DEF * mdc_pkg::GRID_SIDE_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/mdc_nbr.sv
// Shared neighbor unit: coordinates, grid check and cell address of one neighbor.
module mdc_nbr #(
    parameter int GRID_SIDE = mdc_pkg::GRID_SIDE_DEF,
    localparam int CW       = $clog2(GRID_SIDE),
    localparam int AW       = $clog2(GRID_SIDE * GRID_SIDE)
) (
    input  logic [CW-1:0]       i_x,
    input  logic [CW-1:0]       i_y,
    input  mdc_pkg::t_nsel      i_sel,
    output logic [CW-1:0]       o_nx,
    output logic [CW-1:0]       o_ny,
    output logic                o_in_grid,
    output logic [AW-1:0]       o_addr
);
    import mdc_pkg::*;

    logic [CW-1:0] w_nx;
    logic [CW-1:0] w_ny;
    logic          w_in;

    // Step one cell in the chosen direction and check the grid edge
    always_comb begin
        w_nx = i_x;
        w_ny = i_y;
        w_in = 1'b0;
        unique case (i_sel)
            NB_HERE: begin
                w_in = (32'(i_x) < GRID_SIDE) && (32'(i_y) < GRID_SIDE);
            end
            NB_UP: begin
                w_ny = i_y - CW'(1);
                w_in = (i_y != '0);
            end
            NB_LEFT: begin
                w_nx = i_x - CW'(1);
                w_in = (i_x != '0);
            end
            NB_RIGHT: begin
                w_nx = i_x + CW'(1);
                w_in = (32'(i_x) < GRID_SIDE - 1);
            end
            NB_DOWN: begin
                w_ny = i_y + CW'(1);
                w_in = (32'(i_y) < GRID_SIDE - 1);
            end
            default: begin
                w_in = 1'b0;
            end
        endcase
    end

    // Row-major cell address; park at zero off the grid
    assign o_addr    = w_in ? AW'(32'(w_ny) * GRID_SIDE + 32'(w_nx)) : '0;
    assign o_nx      = w_nx;
    assign o_ny      = w_ny;
    assign o_in_grid = w_in;

endmodule

FILE: rtl/maze_dfs_carver.sv
// Top level of the depth-first maze carver: command sequencer, cell store and path stack.
//
//  Channel  | Dir | Signals                          | Carries
//  ---------+-----+----------------------------------+------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready/tdata[15:0] | command, rnd_dir, cell_x/y, clear_mask
//  m_axis   | out | m_axis_tvalid/tready/tdata[15:0] | status, pos_x, pos_y, cell_bits
//
// Read, clear-bits, start, idle-step and unknown commands run S_RDC, S_RDW, S_OUT. A step
// runs S_TOP, S_TOPLD, S_SCAN, S_DEC, then S_CARVE and S_PUSH on a move, S_OUT if none;
// each dead-end cell it pops returns to S_TOP, and an emptied stack ends via S_RDC, S_RDW.
// Every neighbor probe is one read of the cell store through the neighbor unit.
// Clear grid writes one cell per cycle over all GRID_SIDE*GRID_SIDE cells.
// After reset a clearing pass over every cell runs before s_axis_tready rises.
// One command is in flight at a time; a finished result waits in the output register
// while the next command is accepted, and the sequencer stalls only to hand over a result.
module maze_dfs_carver #(
    parameter int GRID_SIDE = mdc_pkg::GRID_SIDE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [2:0] command, [4:3] rnd_dir, [7:5] cell_x, [10:8] cell_y, [15:11] clear_mask
    input  logic [mdc_pkg::DATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [2:0] status, [5:3] pos_x, [8:6] pos_y, [13:9] cell_bits, [15:14] zero
    output logic [mdc_pkg::DATA_W-1:0]  m_axis_tdata
);
    import mdc_pkg::*;

    localparam int CW    = $clog2(GRID_SIDE);
    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int SCW   = $clog2(CELLS + 1);
    localparam int SW    = 2 * CW;
    localparam int NSLOT = 5;

    typedef enum logic [10:0] {
        S_CLR   = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_RDC   = 11'b00000000100,
        S_RDW   = 11'b00000001000,
        S_TOP   = 11'b00000010000,
        S_TOPLD = 11'b00000100000,
        S_SCAN  = 11'b00001000000,
        S_DEC   = 11'b00010000000,
        S_CARVE = 11'b00100000000,
        S_PUSH  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    // Control state
    logic [AW-1:0]     r_clr_addr;
    logic              r_clr_cmd;
    logic [SCW-1:0]    r_count;
    logic [CW-1:0]     r_walk_x;
    logic [CW-1:0]     r_walk_y;
    logic              r_active;
    logic [2:0]        r_cnt;
    logic              r_m_valid;

    // Command and work registers
    logic [CMD_W-1:0]   r_cmd;
    logic [1:0]         r_rnd;
    logic [COORD_W-1:0] r_cx;
    logic [COORD_W-1:0] r_cy;
    logic [CELL_W-1:0]  r_mask;
    logic               r_in_q;
    logic [CELL_W-1:0]  r_nb_bits [NSLOT];
    logic [NSLOT-1:0]   r_nb_in;
    logic [1:0]         r_dir;
    logic [STAT_W-1:0]  r_res_status;
    logic [COORD_W-1:0] r_res_x;
    logic [COORD_W-1:0] r_res_y;
    logic [CELL_W-1:0]  r_res_bits;
    logic [DATA_W-1:0]  r_m_data;

    // Neighbor unit
    logic [CW-1:0] w_ux, w_uy, w_nx, w_ny;
    t_nsel         w_usel;
    logic          w_uin;
    logic [AW-1:0] w_uaddr;

    // Memories
    logic              w_cw_en;
    logic [AW-1:0]     w_cw_addr;
    logic [CELL_W-1:0] w_cw_data;
    logic [CELL_W-1:0] w_cell_rd;
    logic              w_sw_en;
    logic [AW-1:0]     w_sw_addr;
    logic [SW-1:0]     w_sw_data;
    logic [SW-1:0]     w_stack_rd;
    logic [SCW-1:0]    w_cnt_m1;

    // Decode helpers
    logic              w_s_acc;
    logic              w_m_free;
    logic              w_inside;
    logic [3:0]        w_unv;
    logic              w_found;
    logic [1:0]        w_pick;
    logic [2:0]        w_push_slot;
    logic [CELL_W-1:0] w_there_new;

    assign w_s_acc     = s_axis_tvalid && s_axis_tready;
    assign w_m_free    = !r_m_valid || m_axis_tready;
    assign w_inside    = (32'(r_cx) < GRID_SIDE) && (32'(r_cy) < GRID_SIDE);
    assign w_cnt_m1    = r_count - SCW'(1);
    assign w_push_slot = 3'(r_dir) + 3'd1;
    assign w_there_new = r_nb_bits[w_push_slot] & ~(far_wall(r_dir) | BIT_UNVISITED);

    // Probe the walk cell on a step, the commanded cell otherwise
    assign w_ux = (r_cmd == CMD_STEP) ? r_walk_x : CW'(r_cx);
    assign w_uy = (r_cmd == CMD_STEP) ? r_walk_y : CW'(r_cy);

    always_comb begin
        unique case (r_state)
            S_SCAN:  w_usel = t_nsel'(r_cnt);
            S_PUSH:  w_usel = t_nsel'(w_push_slot);
            default: w_usel = NB_HERE;
        endcase
    end

    mdc_nbr #(
        .GRID_SIDE (GRID_SIDE)
    ) u_nbr (
        .i_x       (w_ux),
        .i_y       (w_uy),
        .i_sel     (w_usel),
        .o_nx      (w_nx),
        .o_ny      (w_ny),
        .o_in_grid (w_uin),
        .o_addr    (w_uaddr)
    );

    // Unvisited in-grid neighbors, one per direction
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_unv[k] = r_nb_in[k+1] && r_nb_bits[k+1][UNV_POS];
        end
    end

    // First free direction at or after the random start, no wrap
    always_comb begin
        w_found = 1'b0;
        w_pick  = DIR_UP;
        for (int d = 3; d >= 0; d--) begin
            if (w_unv[d] && (2'(d) >= r_rnd)) begin
                w_found = 1'b1;
                w_pick  = 2'(d);
            end
        end
    end

    // Cell store write port
    always_comb begin
        w_cw_en   = 1'b0;
        w_cw_addr = w_uaddr;
        w_cw_data = w_cell_rd;
        unique case (r_state)
            S_CLR: begin
                w_cw_en   = 1'b1;
                w_cw_addr = r_clr_addr;
                w_cw_data = BITS_ALL;
            end
            S_RDW: begin
                if (w_inside && r_cmd == CMD_CLEAR_BITS) begin
                    w_cw_en   = 1'b1;
                    w_cw_data = w_cell_rd & ~r_mask;
                end else if (w_inside && r_cmd == CMD_START) begin
                    w_cw_en   = 1'b1;
                    w_cw_data = w_cell_rd & ~BIT_UNVISITED;
                end
            end
            S_CARVE: begin
                w_cw_en   = 1'b1;
                w_cw_data = r_nb_bits[0] & ~own_wall(r_dir);
            end
            S_PUSH: begin
                w_cw_en   = 1'b1;
                w_cw_data = w_there_new;
            end
            default: begin
                w_cw_en = 1'b0;
            end
        endcase
    end

    // Path stack write port
    always_comb begin
        w_sw_en   = 1'b0;
        w_sw_addr = r_count[AW-1:0];
        w_sw_data = {w_ny, w_nx};
        unique case (r_state)
            S_RDW: begin
                if (w_inside && r_cmd == CMD_START) begin
                    w_sw_en   = 1'b1;
                    w_sw_addr = '0;
                    w_sw_data = {CW'(r_cy), CW'(r_cx)};
                end
            end
            S_PUSH: begin
                w_sw_en = (32'(r_count) < CELLS);
            end
            default: begin
                w_sw_en = 1'b0;
            end
        endcase
    end

    mdc_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk     (i_clk),
        .i_wr_en   (w_cw_en),
        .i_wr_addr (w_cw_addr),
        .i_wr_data (w_cw_data),
        .i_rd_addr (w_uaddr),
        .o_rd_data (w_cell_rd)
    );

    mdc_ram #(
        .WIDTH (SW),
        .DEPTH (CELLS)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (w_sw_en),
        .i_wr_addr (w_sw_addr),
        .i_wr_data (w_sw_data),
        .i_rd_addr (w_cnt_m1[AW-1:0]),
        .o_rd_data (w_stack_rd)
    );

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR: begin
                if (32'(r_clr_addr) == CELLS - 1) begin
                    n_state = r_clr_cmd ? S_OUT : S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_s_acc) begin
                    if (s_axis_tdata[2:0] == CMD_CLEAR_GRID) begin
                        n_state = S_CLR;
                    end else if (s_axis_tdata[2:0] == CMD_STEP && r_active) begin
                        n_state = S_TOP;
                    end else begin
                        n_state = S_RDC;
                    end
                end
            end
            S_RDC:   n_state = S_RDW;
            S_RDW:   n_state = S_OUT;
            S_TOP:   n_state = (r_count == '0) ? S_RDC : S_TOPLD;
            S_TOPLD: n_state = S_SCAN;
            S_SCAN:  n_state = (r_cnt == 3'(NSLOT)) ? S_DEC : S_SCAN;
            S_DEC: begin
                if (w_unv == '0) begin
                    n_state = S_TOP;
                end else begin
                    n_state = w_found ? S_CARVE : S_OUT;
                end
            end
            S_CARVE: n_state = S_PUSH;
            S_PUSH:  n_state = S_OUT;
            S_OUT:   n_state = w_m_free ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_addr <= '0;
            r_clr_cmd  <= 1'b0;
            r_count    <= '0;
            r_walk_x   <= '0;
            r_walk_y   <= '0;
            r_active   <= 1'b0;
            r_cnt      <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (32'(r_clr_addr) == CELLS - 1) begin
                        r_count  <= '0;
                        r_active <= 1'b0;
                    end
                end
                S_IDLE: begin
                    r_clr_addr <= '0;
                    r_clr_cmd  <= 1'b1;
                end
                S_RDW: begin
                    if (w_inside && r_cmd == CMD_START) begin
                        r_count  <= SCW'(1);
                        r_walk_x <= CW'(r_cx);
                        r_walk_y <= CW'(r_cy);
                        r_active <= 1'b1;
                    end
                end
                S_TOP: begin
                    if (r_count == '0) begin
                        r_active <= 1'b0;
                    end
                end
                S_TOPLD: begin
                    r_walk_x <= w_stack_rd[CW-1:0];
                    r_walk_y <= w_stack_rd[SW-1:CW];
                    r_cnt    <= '0;
                end
                S_SCAN: begin
                    r_cnt <= r_cnt + 3'd1;
                end
                S_DEC: begin
                    if (w_unv == '0) begin
                        r_count <= w_cnt_m1;
                    end
                end
                S_PUSH: begin
                    if (32'(r_count) < CELLS) begin
                        r_count <= r_count + SCW'(1);
                    end
                    r_walk_x <= w_nx;
                    r_walk_y <= w_ny;
                end
                default: begin
                end
            endcase

            // Output register: drop on take, load from the sequencer when free
            if (r_state == S_OUT && w_m_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Payload and work registers
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_cmd  <= s_axis_tdata[2:0];
            r_rnd  <= s_axis_tdata[4:3];
            r_cx   <= s_axis_tdata[7:5];
            r_cy   <= s_axis_tdata[10:8];
            r_mask <= s_axis_tdata[15:11];
        end

        // Capture each neighbor probe in the cycle after its address
        if (r_state == S_SCAN) begin
            r_in_q <= w_uin;
            if (r_cnt != '0) begin
                r_nb_bits[r_cnt - 3'd1] <= w_cell_rd;
                r_nb_in[r_cnt - 3'd1]   <= r_in_q;
            end
        end

        unique case (r_state)
            S_CLR: begin
                r_res_status <= ST_ACK;
                r_res_x      <= r_cx;
                r_res_y      <= r_cy;
                r_res_bits   <= w_inside ? BITS_ALL : '0;
            end
            S_RDW: begin
                // A finished walk reports its last position, other commands their cell
                r_res_x <= (r_cmd == CMD_STEP) ? COORD_W'(r_walk_x) : r_cx;
                r_res_y <= (r_cmd == CMD_STEP) ? COORD_W'(r_walk_y) : r_cy;
                unique case (r_cmd)
                    CMD_CLEAR_BITS: begin
                        r_res_status <= ST_ACK;
                        r_res_bits   <= w_inside ? (w_cell_rd & ~r_mask) : '0;
                    end
                    CMD_START: begin
                        r_res_status <= ST_ACK;
                        r_res_bits   <= w_inside ? (w_cell_rd & ~BIT_UNVISITED) : '0;
                    end
                    CMD_STEP: begin
                        r_res_status <= ST_FINISHED;
                        r_res_bits   <= w_cell_rd;
                    end
                    CMD_READ: begin
                        r_res_status <= ST_READ;
                        r_res_bits   <= w_inside ? w_cell_rd : '0;
                    end
                    default: begin
                        r_res_status <= ST_ACK;
                        r_res_bits   <= w_inside ? w_cell_rd : '0;
                    end
                endcase
            end
            S_DEC: begin
                r_dir        <= w_pick;
                r_res_status <= ST_NO_MOVE;
                r_res_x      <= COORD_W'(r_walk_x);
                r_res_y      <= COORD_W'(r_walk_y);
                r_res_bits   <= r_nb_bits[0];
            end
            S_PUSH: begin
                r_res_status <= ST_MOVED;
                r_res_x      <= COORD_W'(w_nx);
                r_res_y      <= COORD_W'(w_ny);
                r_res_bits   <= w_there_new;
            end
            default: begin
            end
        endcase

        if (r_state == S_OUT && w_m_free) begin
            r_m_data <= {2'b00, r_res_bits, r_res_y, r_res_x, r_res_status};
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

FILE: rtl/mdc_chk.sv
// Port-level checker of the maze carver, bound to the top level.
module mdc_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [mdc_pkg::DATA_W-1:0]  m_axis_tdata
);
    import mdc_pkg::*;

    // One command at a time: input closes right after a transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input still ready after accepting a command");

    // A new result only comes out of a busy sequencer
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared while the sequencer was idle");

    // A carved cell is always reported visited
    a_moved_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[2:0] == ST_MOVED) |-> !m_axis_tdata[13])
        else $error("moved into a cell still marked unvisited");

    // Hold a stalled result
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed or dropped");

endmodule

bind maze_dfs_carver mdc_chk u_mdc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/maze_dfs_carver_tb.sv
// Self-checking testbench of the depth-first maze carver: command stream in, checked results out.
module maze_dfs_carver_tb;
    import mdc_pkg::*;

    localparam int MAZE_SIDE   = GRID_SIDE_DEF;
    localparam int CELLS       = MAZE_SIDE * MAZE_SIDE;
    localparam int RANDOM_CMDS = 1600;
    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 64;
    localparam int HOLD_CYCLES = 400;

    // Command codes the block does not define
    localparam logic [CMD_W-1:0] CMD_RSV5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSV6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSV7 = 3'd7;

    // Input transaction, last field in the low bits
    typedef struct packed {
        logic [CELL_W-1:0]  clear_mask;
        logic [COORD_W-1:0] cell_y;
        logic [COORD_W-1:0] cell_x;
        logic [1:0]         rnd_dir;
        logic [CMD_W-1:0]   command;
    } t_maze_cmd;

    // Output transaction, last field in the low bits
    typedef struct packed {
        logic [1:0]         pad;
        logic [CELL_W-1:0]  cell_bits;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_x;
        logic [STAT_W-1:0]  status;
    } t_maze_res;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [DATA_W-1:0]   s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [DATA_W-1:0]   m_axis_tdata;

    // Predicted maze state
    logic [CELL_W-1:0]   maze_cells [CELLS];
    logic [5:0]          trail [CELLS];
    int unsigned         trail_depth;
    logic [COORD_W-1:0]  walk_col;
    logic [COORD_W-1:0]  walk_row;
    bit                  walking;

    t_maze_cmd           cmd_pending_q [$];
    t_maze_res           carve_expect_q [$];
    int unsigned         cmds_total;
    int unsigned         cmds_sent = 0;
    int unsigned         results_seen = 0;
    int unsigned         mismatches = 0;
    int unsigned         quiet_cycles = 0;
    int unsigned         hold_left = 0;
    bit                  hold_done = 1'b0;
    int unsigned         pressure_mark;
    int unsigned         tx_idle_pct;
    int unsigned         rx_idle_pct;

    maze_dfs_carver #(
        .GRID_SIDE(MAZE_SIDE)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Idle rates per phase: sender light / receiver heavy, then swapped, then none
    always_comb begin
        if (cmds_sent < cmds_total / 3) begin
            tx_idle_pct = 7;
            rx_idle_pct = 57;
        end else if (cmds_sent < 2 * cmds_total / 3) begin
            tx_idle_pct = 57;
            rx_idle_pct = 7;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    end

    function automatic bit fresh_at(int x, int y);
        if (x < 0 || x >= MAZE_SIDE || y < 0 || y >= MAZE_SIDE)
            return 1'b0;
        return maze_cells[y * MAZE_SIDE + x][UNV_POS];
    endfunction

    function automatic bit has_fresh_neighbor(int x, int y);
        return fresh_at(x - 1, y) || fresh_at(x + 1, y) ||
               fresh_at(x, y - 1) || fresh_at(x, y + 1);
    endfunction

    // Apply one command to the predicted maze and return the result it must produce
    function automatic t_maze_res carve_predict(t_maze_cmd c);
        t_maze_res         r;
        logic [5:0]        here;
        logic [5:0]        there;
        logic [CELL_W-1:0] open_here;
        logic [CELL_W-1:0] open_there;
        int                nx;
        int                ny;
        bit                settled;
        bit                moved;
        r = '0;
        r.status = ST_ACK;
        r.pos_x = c.cell_x;
        r.pos_y = c.cell_y;
        // coordinates are 3 bits wide, so every addressed cell lies in the grid
        here = {c.cell_y, c.cell_x};
        case (c.command)
            CMD_CLEAR_GRID: begin
                foreach (maze_cells[i])
                    maze_cells[i] = BITS_ALL;
                trail_depth = 0;
                walking = 1'b0;
            end
            CMD_CLEAR_BITS: maze_cells[here] = maze_cells[here] & ~c.clear_mask;
            CMD_START: begin
                maze_cells[here] = maze_cells[here] & ~BIT_UNVISITED;
                trail[0] = here;
                trail_depth = 1;
                walk_col = c.cell_x;
                walk_row = c.cell_y;
                walking = 1'b1;
            end
            CMD_READ: r.status = ST_READ;
            CMD_STEP: begin
                // drop dead ends off the top of the path
                settled = 1'b0;
                if (walking) begin
                    while (trail_depth > 0 && !settled) begin
                        walk_col = trail[trail_depth - 1][2:0];
                        walk_row = trail[trail_depth - 1][5:3];
                        if (has_fresh_neighbor(int'(walk_col), int'(walk_row)))
                            settled = 1'b1;
                        else
                            trail_depth--;
                    end
                    if (trail_depth == 0)
                        walking = 1'b0;
                end
                if (!walking) begin
                    r.status = ST_FINISHED;
                end else begin
                    // try directions from the random start onward, no wrap
                    r.status = ST_NO_MOVE;
                    moved = 1'b0;
                    for (int d = int'(c.rnd_dir); d < 4 && !moved; d++) begin
                        nx = int'(walk_col);
                        ny = int'(walk_row);
                        case (2'(d))
                            DIR_UP: begin
                                ny = ny - 1;
                                open_here = BIT_UP;
                                open_there = BIT_DOWN;
                            end
                            DIR_LEFT: begin
                                nx = nx - 1;
                                open_here = BIT_LEFT;
                                open_there = BIT_RIGHT;
                            end
                            DIR_RIGHT: begin
                                nx = nx + 1;
                                open_here = BIT_RIGHT;
                                open_there = BIT_LEFT;
                            end
                            default: begin
                                ny = ny + 1;
                                open_here = BIT_DOWN;
                                open_there = BIT_UP;
                            end
                        endcase
                        if (fresh_at(nx, ny)) begin
                            there = 6'(ny * MAZE_SIDE + nx);
                            maze_cells[{walk_row, walk_col}] =
                                maze_cells[{walk_row, walk_col}] & ~open_here;
                            maze_cells[there] = maze_cells[there] & ~(open_there | BIT_UNVISITED);
                            if (trail_depth < CELLS) begin
                                trail[trail_depth] = there;
                                trail_depth++;
                            end
                            walk_col = there[2:0];
                            walk_row = there[5:3];
                            r.status = ST_MOVED;
                            moved = 1'b1;
                        end
                    end
                end
                r.pos_x = walk_col;
                r.pos_y = walk_row;
                here = {walk_row, walk_col};
            end
            default: ;
        endcase
        r.cell_bits = maze_cells[here];
        return r;
    endfunction

    task automatic push_cmd(input logic [CMD_W-1:0] cmd, input logic [1:0] dir,
                            input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic [CELL_W-1:0] mask);
        t_maze_cmd c;
        c.command = cmd;
        c.rnd_dir = dir;
        c.cell_x = x;
        c.cell_y = y;
        c.clear_mask = mask;
        cmd_pending_q.push_back(c);
    endtask

    // Queue one command with random direction, cell and mask
    task automatic push_rand(input logic [CMD_W-1:0] cmd);
        push_cmd(cmd, 2'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                 CELL_W'($urandom));
    endtask

    task automatic report_mismatch(input string what, input int unsigned idx,
                                   input int got, input int want);
        mismatches++;
        $display("mismatch at result %0d: %s got %0d expected %0d", idx, what, got, want);
    endtask

    // Drive commands from the pending queue and predict each accepted one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                carve_expect_q.push_back(carve_predict(t_maze_cmd'(s_axis_tdata)));
                cmds_sent <= cmds_sent + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (cmd_pending_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= cmd_pending_q.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Throttle the result side; hold off once for a long stretch to back up the input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && cmds_sent >= pressure_mark) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Compare each result with the oldest prediction
    always @(posedge i_clk) begin
        t_maze_res got;
        t_maze_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_maze_res'(m_axis_tdata);
            if (carve_expect_q.size() == 0) begin
                report_mismatch("unexpected result, data", results_seen, int'(m_axis_tdata), 0);
            end else begin
                want = carve_expect_q.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", results_seen, int'(got.status),
                                    int'(want.status));
                if (got.pos_x !== want.pos_x)
                    report_mismatch("pos_x", results_seen, int'(got.pos_x), int'(want.pos_x));
                if (got.pos_y !== want.pos_y)
                    report_mismatch("pos_y", results_seen, int'(got.pos_y), int'(want.pos_y));
                if (got.cell_bits !== want.cell_bits)
                    report_mismatch("cell_bits", results_seen, int'(got.cell_bits),
                                    int'(want.cell_bits));
            end
            results_seen <= results_seen + 1;
        end
    end

    // End the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned n_steps;
        int unsigned n_marks;
        int unsigned pick;
        int unsigned directed;

        // predicted state after reset
        foreach (maze_cells[i])
            maze_cells[i] = BITS_ALL;
        foreach (trail[i])
            trail[i] = '0;
        trail_depth = 0;
        walk_col = '0;
        walk_row = '0;
        walking = 1'b0;

        // Directed: reads, idle step, mask extremes, undefined codes
        push_cmd(CMD_READ, DIR_UP, 3'd0, 3'd0, 5'd0);
        push_cmd(CMD_READ, DIR_DOWN, 3'd7, 3'd7, BITS_ALL);
        push_cmd(CMD_STEP, DIR_UP, 3'd0, 3'd0, 5'd0);
        push_cmd(CMD_CLEAR_BITS, DIR_UP, 3'd0, 3'd0, BIT_UP);
        push_cmd(CMD_CLEAR_BITS, DIR_UP, 3'd7, 3'd7, 5'd0);
        push_cmd(CMD_CLEAR_BITS, DIR_UP, 3'd3, 3'd5, BITS_ALL);
        push_cmd(CMD_RSV5, DIR_DOWN, 3'd1, 3'd2, BITS_ALL);
        push_cmd(CMD_RSV6, DIR_LEFT, 3'd7, 3'd0, 5'd10);
        push_cmd(CMD_RSV7, DIR_RIGHT, 3'd0, 3'd7, 5'd21);
        // Walk from a corner with every start direction
        push_cmd(CMD_START, DIR_UP, 3'd0, 3'd0, 5'd0);
        push_cmd(CMD_STEP, DIR_UP, 3'd0, 3'd0, 5'd0);
        push_cmd(CMD_STEP, DIR_LEFT, 3'd0, 3'd0, 5'd0);
        push_cmd(CMD_STEP, DIR_RIGHT, 3'd0, 3'd0, 5'd0);
        push_cmd(CMD_STEP, DIR_DOWN, 3'd0, 3'd0, 5'd0);
        push_cmd(CMD_STEP, DIR_DOWN, 3'd0, 3'd0, 5'd0);
        // Restart while walking; a step off the grid edge cannot move
        push_cmd(CMD_START, DIR_UP, 3'd7, 3'd7, 5'd0);
        push_cmd(CMD_STEP, DIR_DOWN, 3'd0, 3'd0, 5'd0);
        push_cmd(CMD_STEP, DIR_UP, 3'd0, 3'd0, 5'd0);
        // Walk boxed in by visited cells: pop to empty, then step while idle
        push_cmd(CMD_CLEAR_GRID, DIR_DOWN, 3'd7, 3'd7, BITS_ALL);
        push_cmd(CMD_CLEAR_BITS, DIR_UP, 3'd1, 3'd0, BIT_UNVISITED);
        push_cmd(CMD_CLEAR_BITS, DIR_UP, 3'd0, 3'd1, BIT_UNVISITED);
        push_cmd(CMD_START, DIR_UP, 3'd0, 3'd0, 5'd0);
        push_cmd(CMD_STEP, DIR_UP, 3'd0, 3'd0, 5'd0);
        push_cmd(CMD_STEP, DIR_RIGHT, 3'd0, 3'd0, 5'd0);
        directed = cmd_pending_q.size();

        // Random: mostly walks with random directions, some noise bursts
        while (cmd_pending_q.size() < directed + RANDOM_CMDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                if ($urandom_range(0, 2) != 0)
                    push_rand(CMD_CLEAR_GRID);
                n_marks = $urandom_range(0, 3);
                repeat (n_marks)
                    push_rand(CMD_CLEAR_BITS);
                push_rand(CMD_START);
                n_steps = $urandom_range(10, 150);
                repeat (n_steps) begin
                    if ($urandom_range(0, 9) == 0)
                        push_rand(CMD_READ);
                    else
                        push_rand(CMD_STEP);
                end
            end else begin
                n_steps = $urandom_range(1, 10);
                repeat (n_steps)
                    push_rand(CMD_W'($urandom_range(0, 7)));
            end
        end
        cmds_total = cmd_pending_q.size();
        pressure_mark = directed + 300;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all commands taken, all results back, then a quiet margin
        while (cmd_pending_q.size() != 0 || s_axis_tvalid || carve_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
